// ===== sv/mnd_pkg.sv =====
// Shared constants, types and the output saturation function for the
// Miyamoto-Nagai disk force block. No dependencies.
package mnd_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MUL_CHUNK     = 32;
  localparam int MUL_LAT       = 2;
  localparam int QUO_W         = 32;
  localparam int CFG_IDX_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GRAV_MASS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_RADIAL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_VERTICAL = 2'd2;

  localparam logic [DATA_W-1:0] NEG_LIMIT = 32'h8000_0000;
  localparam logic [DATA_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;

  typedef struct packed {
    logic              clip;
    logic [DATA_W-1:0] word;
  } sat_t;

  // Clamp a magnitude to the signed range and apply the sign.
  function automatic sat_t sat_word(input logic [DATA_W-1:0] mag, input logic big,
                                    input logic neg);
    logic [DATA_W-1:0] lim;
    logic [DATA_W-1:0] m;
    sat_t              res;
    lim      = neg ? NEG_LIMIT : POS_LIMIT;
    res.clip = big || (mag > lim);
    m        = res.clip ? lim : mag;
    res.word = neg ? (~m + 32'd1) : m;
    return res;
  endfunction

endpackage

// ===== sv/mnd_delay.sv =====
// Delay line with a shared advance enable, used to keep side data aligned
// with the arithmetic pipeline. Depends on nothing.
module mnd_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  assign q = tap[DEPTH-1];

endmodule

// ===== sv/mnd_mul.sv =====
// Two-stage unsigned multiplier built from 32 by 32 partial products.
// Depends on mnd_pkg.
module mnd_mul #(
  parameter int A_W = 32,
  parameter int B_W = 32
) (
  input  logic               clk,
  input  logic               en,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] p
);
  import mnd_pkg::*;

  localparam int NA   = (A_W + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int NB   = (B_W + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int AP_W = NA * MUL_CHUNK;
  localparam int BP_W = NB * MUL_CHUNK;
  localparam int P_W  = A_W + B_W;

  logic [AP_W-1:0]          a_pad;
  logic [BP_W-1:0]          b_pad;
  logic [2*MUL_CHUNK-1:0]   pp [NA][NB];
  logic [P_W-1:0]           acc;

  assign a_pad = AP_W'(a);
  assign b_pad = BP_W'(b);

  // First stage: partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= a_pad[i*MUL_CHUNK +: MUL_CHUNK] * b_pad[j*MUL_CHUNK +: MUL_CHUNK];
        end
      end
    end
  end

  // Second stage: weighted sum of the partial products.
  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (P_W'(pp[i][j]) << (MUL_CHUNK * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= acc;
    end
  end

endmodule

// ===== sv/mnd_sqrt.sv =====
// Pipelined integer square root, one result bit per stage (floor of the
// root). Depends on nothing.
module mnd_sqrt #(
  parameter int IN_W = 66
) (
  input  logic                clk,
  input  logic                en,
  input  logic [IN_W-1:0]     rad,
  output logic [IN_W/2-1:0]   root
);

  localparam int OUT_W = IN_W / 2;
  localparam int REM_W = OUT_W + 2;

  logic [REM_W-1:0] rem_q  [OUT_W];
  logic [OUT_W-1:0] root_q [OUT_W];
  logic [IN_W-1:0]  rad_q  [OUT_W];

  for (genvar k = 0; k < OUT_W; k++) begin : g_stage
    logic [REM_W-1:0] rem_i;
    logic [REM_W-1:0] rem_t;
    logic [REM_W-1:0] trial;
    logic [OUT_W-1:0] root_i;
    logic [IN_W-1:0]  rad_i;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = rad;
    end else begin : g_next
      assign rem_i  = rem_q[k-1];
      assign root_i = root_q[k-1];
      assign rad_i  = rad_q[k-1];
    end

    // Bring down the next two radicand bits and try 4*root + 1.
    assign rem_t = {rem_i[REM_W-3:0], rad_i[IN_W-1 -: 2]};
    assign trial = {root_i, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_t >= trial) begin
          rem_q[k]  <= rem_t - trial;
          root_q[k] <= {root_i[OUT_W-2:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_t;
          root_q[k] <= {root_i[OUT_W-2:0], 1'b0};
        end
        rad_q[k] <= rad_i << 2;
      end
    end
  end

  assign root = root_q[OUT_W-1];

endmodule

// ===== sv/mnd_div.sv =====
// Pipelined restoring divider producing a Q_W-bit quotient and a flag for
// quotients of 2^Q_W and above. Depends on nothing.
module mnd_div #(
  parameter int N_W = 96,
  parameter int D_W = 105,
  parameter int Q_W = 32
) (
  input  logic           clk,
  input  logic           en,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  output logic [Q_W-1:0] quo,
  output logic           ovf
);

  localparam int CMP_W = (N_W > D_W + Q_W) ? N_W : D_W + Q_W;

  logic [D_W-1:0] rem_q [Q_W+1];
  logic [Q_W-1:0] lq_q  [Q_W+1];
  logic [D_W-1:0] den_q [Q_W+1];
  logic           ovf_q [Q_W+1];

  // When the quotient fits, the upper dividend bits are already below the
  // divisor and only the low Q_W bits need to be brought down.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= D_W'(num >> Q_W);
      lq_q[0]  <= num[Q_W-1:0];
      den_q[0] <= den;
      ovf_q[0] <= CMP_W'(num) >= (CMP_W'(den) << Q_W);
    end
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_stage
    logic [D_W:0] rem_t;
    logic [D_W:0] diff;
    logic         ge;

    assign rem_t = {rem_q[k-1], lq_q[k-1][Q_W-1]};
    assign diff  = rem_t - {1'b0, den_q[k-1]};
    assign ge    = rem_t >= {1'b0, den_q[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? diff[D_W-1:0] : rem_t[D_W-1:0];
        lq_q[k]  <= {lq_q[k-1][Q_W-2:0], ge};
        den_q[k] <= den_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign quo = lq_q[Q_W];
  assign ovf = ovf_q[Q_W];

endmodule

// ===== sv/miyamoto_nagai_disk_force_core.sv =====
// Top level of the Miyamoto-Nagai disk force block: configuration registers,
// the arithmetic pipeline and the output register. Depends on mnd_pkg,
// mnd_mul, mnd_sqrt, mnd_div and mnd_delay.
//
// Usage. Positions arrive as words on the s_ stream channel, one per cycle
// at most, and each produces exactly one result word on the m_ channel: the
// acceleration (x, y, z), the potential and a saturation flag on m_tuser.
// GM, a and b are written through the plain cfg_ write port; the user must
// write them only while the block is idle (the block does not enforce it).
// A write takes effect at the clock edge on which cfg_we is high. Each word
// passes two square roots (33 and 35 stages), two 33-stage dividers in
// series and the multipliers between them; the delay to m_tvalid does not
// vary with the data. Throughput is one word per cycle while m_tready holds.
// Reset (synchronous, active high) empties the pipeline and the output
// register and sets all three parameters to 1.0.
// When the receiver stalls, the result waits in the output register and the
// pipeline keeps advancing until its last stage also holds a result; only
// then does s_tready fall. Nothing is dropped or duplicated.
module miyamoto_nagai_disk_force_core #(
  parameter int FRAC_BITS = mnd_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // pos_x [31:0], pos_y [63:32], pos_z [95:64]
  input  logic [3*mnd_pkg::DATA_W-1:0]   s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // accel_x [31:0], accel_y [63:32], accel_z [95:64], pot_value [127:96]
  output logic [4*mnd_pkg::DATA_W-1:0]   m_tdata,
  // clipped [0]
  output logic [0:0]                     m_tuser,
  input  logic                           cfg_we,
  input  logic [mnd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mnd_pkg::DATA_W-1:0]     cfg_data
);
  import mnd_pkg::*;

  // Widths of the intermediate values.
  localparam int T_W    = 33;          // t = sqrt(z^2 + b^2)
  localparam int S_W    = 34;          // s = a + t
  localparam int W_W    = 35;          // w = sqrt(s^2 + rc^2)
  localparam int NUM_W  = 2 * DATA_W + 2 * FRAC_BITS;
  localparam int POT_W  = DATA_W + FRAC_BITS;
  localparam int QS_W   = QUO_W + S_W;
  localparam int DIV_LAT = QUO_W + 1;

  // Pipeline index at which each value sits in a register.
  localparam int T_IN   = 1;
  localparam int T_SQ   = T_IN + MUL_LAT;
  localparam int T_SUM1 = T_SQ + 1;
  localparam int T_T    = T_SUM1 + T_W;
  localparam int T_S    = T_T + 1;
  localparam int T_S2   = T_S + MUL_LAT;
  localparam int T_SUM2 = T_S2 + 1;
  localparam int T_WV   = T_SUM2 + W_W;
  localparam int T_W2   = T_WV + MUL_LAT;
  localparam int T_W3   = T_W2 + MUL_LAT;
  localparam int T_Q    = T_W3 + DIV_LAT;
  localparam int T_QS   = T_Q + MUL_LAT;
  localparam int T_END  = T_QS + DIV_LAT;

  logic [DATA_W-1:0] grav_mass;
  logic [DATA_W-1:0] scale_radial;
  logic [DATA_W-1:0] scale_vertical;

  logic              advance;
  logic [T_END:T_IN] vld;

  logic [DATA_W-1:0]   mag [3];
  logic [2:0]          neg_in;
  logic [2*DATA_W-1:0] sq [3];
  logic [2*DATA_W-1:0] sq_b;
  logic [2*DATA_W-1:0] gp [3];
  logic [2*DATA_W-1:0] gp_d [3];
  logic [2*DATA_W:0]   zb_sum;
  logic [2*DATA_W-1:0] rc2;
  logic [2*DATA_W-1:0] rc2_d;
  logic [T_W-1:0]      t_val;
  logic [T_W-1:0]      t_d;
  logic [S_W-1:0]      s_val;
  logic [S_W-1:0]      s_d;
  logic [2*S_W-1:0]    s2;
  logic [2*S_W:0]      w_rad;
  logic [W_W-1:0]      w_val;
  logic [W_W-1:0]      w_d2;
  logic [W_W-1:0]      w_d4;
  logic [2*W_W-1:0]    w2;
  logic [3*W_W-1:0]    w3;
  logic [QUO_W-1:0]    q [3];
  logic                q_ovf [3];
  logic [QUO_W-1:0]    qp;
  logic                qp_ovf;
  logic [QS_W-1:0]     qs;
  logic [QUO_W-1:0]    qz2;
  logic                qz2_ovf;
  logic                z_big;

  // Values aligned to the last stage.
  logic [3*(QUO_W+1)-1:0] xyp_e;
  logic [2:0]             neg_e;
  logic                   z_big_e;
  logic                   t_zero_e;
  logic                   w_zero_e;

  sat_t              sx, sy, sz, sp;
  logic [DATA_W-1:0] out_x, out_y, out_z, out_p;
  logic              out_clip;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      grav_mass      <= DATA_W'(1) << FRAC_BITS;
      scale_radial   <= DATA_W'(1) << FRAC_BITS;
      scale_vertical <= DATA_W'(1) << FRAC_BITS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRAV_MASS:      grav_mass      <= cfg_data;
        REG_SCALE_RADIAL:   scale_radial   <= cfg_data;
        REG_SCALE_VERTICAL: scale_vertical <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together; it may move whenever its last stage
  // is empty or the output register can take that stage's word.
  assign advance  = !vld[T_END] || !m_tvalid || m_tready;
  assign s_tready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[T_END-1:T_IN], s_tvalid};
    end
  end

  // Input stage: split each coordinate into magnitude and the sign of the
  // force, which points back towards the origin.
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        mag[i]    <= s_tdata[i*DATA_W + DATA_W-1] ?
                     (~s_tdata[i*DATA_W +: DATA_W] + 32'd1) : s_tdata[i*DATA_W +: DATA_W];
        neg_in[i] <= !s_tdata[i*DATA_W + DATA_W-1] && (s_tdata[i*DATA_W +: DATA_W] != '0);
      end
    end
  end

  // Squares of the coordinates and GM times each coordinate magnitude.
  for (genvar i = 0; i < 3; i++) begin : g_lane
    mnd_mul #(.A_W(DATA_W), .B_W(DATA_W)) u_sq (
      .clk(clk), .en(advance), .a(mag[i]), .b(mag[i]), .p(sq[i])
    );
    mnd_mul #(.A_W(DATA_W), .B_W(DATA_W)) u_gp (
      .clk(clk), .en(advance), .a(grav_mass), .b(mag[i]), .p(gp[i])
    );
    mnd_delay #(.W(2*DATA_W), .DEPTH(T_W3 - T_SQ)) u_gp_dly (
      .clk(clk), .en(advance), .d(gp[i]), .q(gp_d[i])
    );
    // Acceleration magnitude before the z correction: GM*|p| / w^3.
    mnd_div #(.N_W(NUM_W), .D_W(3*W_W), .Q_W(QUO_W)) u_div (
      .clk(clk), .en(advance),
      .num({gp_d[i], {(2*FRAC_BITS){1'b0}}}), .den(w3),
      .quo(q[i]), .ovf(q_ovf[i])
    );
  end

  mnd_mul #(.A_W(DATA_W), .B_W(DATA_W)) u_sq_b (
    .clk(clk), .en(advance), .a(scale_vertical), .b(scale_vertical), .p(sq_b)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      zb_sum <= {1'b0, sq[2]} + {1'b0, sq_b};
      rc2    <= sq[0] + sq[1];
    end
  end

  mnd_sqrt #(.IN_W(2*T_W)) u_sqrt_t (
    .clk(clk), .en(advance), .rad({1'b0, zb_sum}), .root(t_val)
  );

  mnd_delay #(.W(2*DATA_W), .DEPTH(T_S2 - T_SUM1)) u_rc2_dly (
    .clk(clk), .en(advance), .d(rc2), .q(rc2_d)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      s_val <= S_W'(scale_radial) + S_W'(t_val);
    end
  end

  mnd_mul #(.A_W(S_W), .B_W(S_W)) u_s2 (
    .clk(clk), .en(advance), .a(s_val), .b(s_val), .p(s2)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      w_rad <= (2*S_W+1)'(s2) + (2*S_W+1)'(rc2_d);
    end
  end

  mnd_sqrt #(.IN_W(2*W_W)) u_sqrt_w (
    .clk(clk), .en(advance), .rad({1'b0, w_rad}), .root(w_val)
  );

  // w^3 in two multiplier passes.
  mnd_mul #(.A_W(W_W), .B_W(W_W)) u_w2 (
    .clk(clk), .en(advance), .a(w_val), .b(w_val), .p(w2)
  );
  mnd_delay #(.W(W_W), .DEPTH(MUL_LAT)) u_w_dly2 (
    .clk(clk), .en(advance), .d(w_val), .q(w_d2)
  );
  mnd_mul #(.A_W(2*W_W), .B_W(W_W)) u_w3 (
    .clk(clk), .en(advance), .a(w2), .b(w_d2), .p(w3)
  );
  mnd_delay #(.W(W_W), .DEPTH(MUL_LAT)) u_w_dly4 (
    .clk(clk), .en(advance), .d(w_d2), .q(w_d4)
  );

  // Potential magnitude GM / w.
  mnd_div #(.N_W(POT_W), .D_W(W_W), .Q_W(QUO_W)) u_div_pot (
    .clk(clk), .en(advance),
    .num({grav_mass, {FRAC_BITS{1'b0}}}), .den(w_d4),
    .quo(qp), .ovf(qp_ovf)
  );

  // z correction: q * s / t. A first quotient above 2^31 saturates anyway,
  // so only smaller ones need the exact product.
  assign z_big = q_ovf[2] || (q[2] > NEG_LIMIT);

  mnd_delay #(.W(S_W), .DEPTH(T_Q - T_S)) u_s_dly (
    .clk(clk), .en(advance), .d(s_val), .q(s_d)
  );
  mnd_mul #(.A_W(QUO_W), .B_W(S_W)) u_qs (
    .clk(clk), .en(advance), .a(q[2]), .b(s_d), .p(qs)
  );
  mnd_delay #(.W(T_W), .DEPTH(T_QS - T_T)) u_t_dly (
    .clk(clk), .en(advance), .d(t_val), .q(t_d)
  );
  mnd_div #(.N_W(QS_W), .D_W(T_W), .Q_W(QUO_W)) u_div_z (
    .clk(clk), .en(advance), .num(qs), .den(t_d), .quo(qz2), .ovf(qz2_ovf)
  );

  // Side information carried to the last stage.
  mnd_delay #(.W(3*(QUO_W+1)), .DEPTH(T_END - T_Q)) u_xyp_dly (
    .clk(clk), .en(advance),
    .d({qp_ovf, qp, q_ovf[1], q[1], q_ovf[0], q[0]}), .q(xyp_e)
  );
  mnd_delay #(.W(3), .DEPTH(T_END - T_IN)) u_neg_dly (
    .clk(clk), .en(advance), .d(neg_in), .q(neg_e)
  );
  mnd_delay #(.W(1), .DEPTH(T_END - T_Q)) u_zbig_dly (
    .clk(clk), .en(advance), .d(z_big), .q(z_big_e)
  );
  mnd_delay #(.W(1), .DEPTH(T_END - T_T)) u_tz_dly (
    .clk(clk), .en(advance), .d(t_val == '0), .q(t_zero_e)
  );
  mnd_delay #(.W(1), .DEPTH(T_END - T_WV)) u_wz_dly (
    .clk(clk), .en(advance), .d(w_val == '0), .q(w_zero_e)
  );

  // Saturation, signs and the two degenerate cases: a zero distance term
  // gives zero force and the most negative potential; a zero t gives no
  // vertical force.
  always_comb begin
    sx = sat_word(xyp_e[QUO_W-1:0], xyp_e[QUO_W], neg_e[0]);
    sy = sat_word(xyp_e[2*QUO_W:QUO_W+1], xyp_e[2*QUO_W+1], neg_e[1]);
    sz = sat_word(qz2, qz2_ovf || z_big_e, neg_e[2]);
    sp = sat_word(xyp_e[3*QUO_W+1:2*QUO_W+2], xyp_e[3*QUO_W+2],
                  xyp_e[3*QUO_W+2] || (xyp_e[3*QUO_W+1:2*QUO_W+2] != '0));
    if (t_zero_e) begin
      sz.word = '0;
      sz.clip = 1'b0;
    end
    if (w_zero_e) begin
      out_x    = '0;
      out_y    = '0;
      out_z    = '0;
      out_p    = NEG_LIMIT;
      out_clip = 1'b1;
    end else begin
      out_x    = sx.word;
      out_y    = sy.word;
      out_z    = sz.word;
      out_p    = sp.word;
      out_clip = sx.clip || sy.clip || sz.clip || sp.clip;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= vld[T_END];
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      m_tdata <= {out_p, out_z, out_y, out_x};
      m_tuser <= out_clip;
    end
  end

endmodule
